>>> src/smp_pkg.sv
package smp_pkg;

  localparam int WORD_W     = 32;
  localparam int TAG_W      = 48;
  localparam int PAIR_W     = 64;
  localparam int N_ROUNDS   = 80;
  localparam int WIN_DEPTH  = 16;
  localparam int ROUND_IDX_W = 7;
  localparam int PREFIX_W   = 6;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  localparam int ROT_A      = 5;
  localparam int ROT_B      = 30;
  localparam int PREFIX_ONE_WORD = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MIDSTATE_AB      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIDSTATE_CD      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MIDSTATE_E       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_WORDS_12_13 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_WORDS_14_15 = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_COMPARE    = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_COMPARE   = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_DIGITS    = CFG_IDX_W'(7);

  localparam logic [7:0] TT_CHOOSE   = 8'hCA;
  localparam logic [7:0] TT_PARITY   = 8'h96;
  localparam logic [7:0] TT_MAJORITY = 8'hE8;

  localparam logic [WORD_W-1:0] K_GRP0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K_GRP1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K_GRP2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K_GRP3 = 32'hCA62C1D6;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [WIN_DEPTH-1:0] window_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic             last;
    word_t            a;
    word_t            b;
    word_t            c;
    word_t            d;
    word_t            e;
    window_t          w;
  } stage_t;

  typedef struct packed {
    logic [PAIR_W-1:0]   midstate_ab;
    logic [PAIR_W-1:0]   midstate_cd;
    word_t               midstate_e;
    logic [PAIR_W-1:0]   tail_words_12_13;
    logic [PAIR_W-1:0]   tail_words_14_15;
    logic [PAIR_W-1:0]   first_compare;
    logic [PAIR_W-1:0]   second_compare;
    logic [PREFIX_W-1:0] prefix_digits;
  } cfg_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             matched;
    word_t            a;
    word_t            b;
    word_t            c;
    word_t            d;
    word_t            e;
    logic             done;
  } res_t;

  function automatic word_t rotl1(input word_t x);
    return {x[WORD_W-2:0], x[WORD_W-1]};
  endfunction

  function automatic word_t rotl_a(input word_t x);
    return {x[WORD_W-1-ROT_A:0], x[WORD_W-1:WORD_W-ROT_A]};
  endfunction

  function automatic word_t rotl_b(input word_t x);
    return {x[WORD_W-1-ROT_B:0], x[WORD_W-1:WORD_W-ROT_B]};
  endfunction

  function automatic word_t ternary(input logic [7:0] tt, input word_t b, input word_t c,
                                    input word_t d);
    word_t f;
    for (int j = 0; j < WORD_W; j++) begin
      f[j] = tt[{b[j], c[j], d[j]}];
    end
    return f;
  endfunction

  function automatic logic [7:0] round_tt(input logic [ROUND_IDX_W-1:0] idx);
    logic [7:0] tt;
    if (int'(idx) < 20) begin
      tt = TT_CHOOSE;
    end else if (int'(idx) < 40) begin
      tt = TT_PARITY;
    end else if (int'(idx) < 60) begin
      tt = TT_MAJORITY;
    end else begin
      tt = TT_PARITY;
    end
    return tt;
  endfunction

  function automatic word_t round_k(input logic [ROUND_IDX_W-1:0] idx);
    word_t k;
    if (int'(idx) < 20) begin
      k = K_GRP0;
    end else if (int'(idx) < 40) begin
      k = K_GRP1;
    end else if (int'(idx) < 60) begin
      k = K_GRP2;
    end else begin
      k = K_GRP3;
    end
    return k;
  endfunction

endpackage

>>> src/smp_if.sv
interface smp_in_if;
  import smp_pkg::*;
  logic              valid;
  logic              ready;
  logic [TAG_W-1:0]  candidate_tag;
  logic [PAIR_W-1:0] words_0_1;
  logic [PAIR_W-1:0] words_2_3;
  logic [PAIR_W-1:0] words_4_5;
  logic [PAIR_W-1:0] words_6_7;
  logic [PAIR_W-1:0] words_8_9;
  logic [PAIR_W-1:0] words_10_11;
  logic              range_last;

  modport source (output valid, candidate_tag, words_0_1, words_2_3, words_4_5, words_6_7,
                  words_8_9, words_10_11, range_last, input ready);
  modport sink (input valid, candidate_tag, words_0_1, words_2_3, words_4_5, words_6_7,
                words_8_9, words_10_11, range_last, output ready);
endinterface

interface smp_out_if;
  import smp_pkg::*;
  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] result_tag;
  logic             matched;
  word_t            digest_a;
  word_t            digest_b;
  word_t            digest_c;
  word_t            digest_d;
  word_t            digest_e;
  logic             range_done;

  modport source (output valid, result_tag, matched, digest_a, digest_b, digest_c, digest_d,
                  digest_e, range_done, input ready);
  modport sink (input valid, result_tag, matched, digest_a, digest_b, digest_c, digest_d,
                digest_e, range_done, output ready);
endinterface

interface smp_cfg_if;
  import smp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/smp_cfg_regs.sv
module smp_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  smp_cfg_if.sink       cfg_ch,
  output smp_pkg::cfg_t cfg
);
  import smp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MIDSTATE_AB:      cfg_nxt.midstate_ab      = cfg_ch.data;
        REG_MIDSTATE_CD:      cfg_nxt.midstate_cd      = cfg_ch.data;
        REG_MIDSTATE_E:       cfg_nxt.midstate_e       = cfg_ch.data[WORD_W-1:0];
        REG_TAIL_WORDS_12_13: cfg_nxt.tail_words_12_13 = cfg_ch.data;
        REG_TAIL_WORDS_14_15: cfg_nxt.tail_words_14_15 = cfg_ch.data;
        REG_FIRST_COMPARE:    cfg_nxt.first_compare    = cfg_ch.data;
        REG_SECOND_COMPARE:   cfg_nxt.second_compare   = cfg_ch.data;
        REG_PREFIX_DIGITS:    cfg_nxt.prefix_digits    = cfg_ch.data[PREFIX_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> src/smp_round_cell.sv
module smp_round_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic [smp_pkg::ROUND_IDX_W-1:0] round_idx,
  input  smp_pkg::stage_t                stage_i,
  output smp_pkg::stage_t                stage_o
);
  import smp_pkg::*;

  stage_t stage_r;
  stage_t stage_nxt;
  word_t  f;
  word_t  w_new;

  assign stage_o = stage_r;

  always_comb begin
    f     = ternary(round_tt(round_idx), stage_i.b, stage_i.c, stage_i.d);
    w_new = rotl1(stage_i.w[13] ^ stage_i.w[8] ^ stage_i.w[2] ^ stage_i.w[0]);

    stage_nxt       = stage_i;
    stage_nxt.a     = rotl_a(stage_i.a) + f + stage_i.e + round_k(round_idx) + stage_i.w[0];
    stage_nxt.b     = stage_i.a;
    stage_nxt.c     = rotl_b(stage_i.b);
    stage_nxt.d     = stage_i.c;
    stage_nxt.e     = stage_i.d;
    for (int j = 0; j < WIN_DEPTH - 1; j++) begin
      stage_nxt.w[j] = stage_i.w[j+1];
    end
    stage_nxt.w[WIN_DEPTH-1] = w_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (adv) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

>>> src/smp_finish.sv
module smp_finish (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  smp_pkg::cfg_t   cfg,
  input  smp_pkg::stage_t stage_i,
  output logic            out_valid,
  output smp_pkg::res_t   res
);
  import smp_pkg::*;

  logic  out_valid_r;
  res_t  res_r;
  res_t  res_nxt;
  logic  hit_a;
  logic  hit_b;

  assign out_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    res_nxt.tag  = stage_i.tag;
    res_nxt.done = stage_i.last;
    res_nxt.a    = stage_i.a + cfg.midstate_ab[PAIR_W-1:WORD_W];
    res_nxt.b    = stage_i.b + cfg.midstate_ab[WORD_W-1:0];
    res_nxt.c    = stage_i.c + cfg.midstate_cd[PAIR_W-1:WORD_W];
    res_nxt.d    = stage_i.d + cfg.midstate_cd[WORD_W-1:0];
    res_nxt.e    = stage_i.e + cfg.midstate_e;
    hit_a = (res_nxt.a & cfg.first_compare[PAIR_W-1:WORD_W]) ==
            cfg.first_compare[WORD_W-1:0];
    hit_b = (res_nxt.b & cfg.second_compare[PAIR_W-1:WORD_W]) ==
            cfg.second_compare[WORD_W-1:0];
    res_nxt.matched = hit_a &&
                      ((cfg.prefix_digits <= PREFIX_W'(PREFIX_ONE_WORD)) || hit_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= stage_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> src/sha1_midstate_prefix_match.sv
// SHA-1 prefix search engine: each request carries a candidate's twelve leading message
// words; the block finishes the 80-round compression from the configured midstate and tail
// words, adds the midstate back, and returns the digest with a masked-prefix match flag.
// A row of 80 round cells, one round each, followed by a finishing stage gives one request
// per cycle in and out unless the output stalls. The whole row advances together, so a
// stalled result holds every request behind it. Write configuration only with the row empty.
module sha1_midstate_prefix_match (
  input  logic      clk,
  input  logic      rst_n,
  smp_in_if.sink    in_ch,
  smp_out_if.source out_ch,
  smp_cfg_if.sink   cfg_ch
);
  import smp_pkg::*;

  cfg_t   cfg;
  stage_t chain [0:N_ROUNDS];
  logic   adv;
  logic   out_valid;
  res_t   res;

  smp_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    chain[0].valid = in_ch.valid;
    chain[0].tag   = in_ch.candidate_tag;
    chain[0].last  = in_ch.range_last;
    chain[0].a     = cfg.midstate_ab[PAIR_W-1:WORD_W];
    chain[0].b     = cfg.midstate_ab[WORD_W-1:0];
    chain[0].c     = cfg.midstate_cd[PAIR_W-1:WORD_W];
    chain[0].d     = cfg.midstate_cd[WORD_W-1:0];
    chain[0].e     = cfg.midstate_e;
    chain[0].w[0]  = in_ch.words_0_1[PAIR_W-1:WORD_W];
    chain[0].w[1]  = in_ch.words_0_1[WORD_W-1:0];
    chain[0].w[2]  = in_ch.words_2_3[PAIR_W-1:WORD_W];
    chain[0].w[3]  = in_ch.words_2_3[WORD_W-1:0];
    chain[0].w[4]  = in_ch.words_4_5[PAIR_W-1:WORD_W];
    chain[0].w[5]  = in_ch.words_4_5[WORD_W-1:0];
    chain[0].w[6]  = in_ch.words_6_7[PAIR_W-1:WORD_W];
    chain[0].w[7]  = in_ch.words_6_7[WORD_W-1:0];
    chain[0].w[8]  = in_ch.words_8_9[PAIR_W-1:WORD_W];
    chain[0].w[9]  = in_ch.words_8_9[WORD_W-1:0];
    chain[0].w[10] = in_ch.words_10_11[PAIR_W-1:WORD_W];
    chain[0].w[11] = in_ch.words_10_11[WORD_W-1:0];
    chain[0].w[12] = cfg.tail_words_12_13[PAIR_W-1:WORD_W];
    chain[0].w[13] = cfg.tail_words_12_13[WORD_W-1:0];
    chain[0].w[14] = cfg.tail_words_14_15[PAIR_W-1:WORD_W];
    chain[0].w[15] = cfg.tail_words_14_15[WORD_W-1:0];
  end

  for (genvar g = 0; g < N_ROUNDS; g++) begin : g_round
    smp_round_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .round_idx (ROUND_IDX_W'(g)),
      .stage_i   (chain[g]),
      .stage_o   (chain[g+1])
    );
  end

  smp_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .cfg       (cfg),
    .stage_i   (chain[N_ROUNDS]),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.result_tag = res.tag;
  assign out_ch.matched    = res.matched;
  assign out_ch.digest_a   = res.a;
  assign out_ch.digest_b   = res.b;
  assign out_ch.digest_c   = res.c;
  assign out_ch.digest_d   = res.d;
  assign out_ch.digest_e   = res.e;
  assign out_ch.range_done = res.done;

endmodule

>>> src/smp_checker.sv
module smp_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [smp_pkg::TAG_W-1:0] out_tag
);
  import smp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_tag_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_tag))
    else $error("result tag changed while stalled");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused with empty output");

  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while output stalled");

endmodule

bind sha1_midstate_prefix_match smp_checker u_smp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_tag   (out_ch.result_tag)
);
